// File: rtl/core/bounded_sorted_list_engine_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sorted list engine
// Concurrent checks on clk_i; removed from synthesis builds.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_SORTED_LIST_ENGINE_ASSERT_SVH
`define BOUNDED_SORTED_LIST_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
// check held off while rst_ni is low
`define BSL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// check that also holds through reset
`define BSL_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define BSL_ASSERT(lbl, prop, msg)
`define BSL_ASSERT_NR(lbl, prop, msg)
`endif
`endif

// File: rtl/core/bsl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsl_pkg
// Shared types and constants of the sorted list engine.
// ----------------------------------------------------------------------------
package bsl_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned FuncW    = 3;
  localparam int unsigned FoundW   = 4;
  localparam int unsigned CountW   = 5;

  typedef enum logic [FuncW-1:0] {
    FUNC_INSERT = 3'd0,
    FUNC_POP    = 3'd1,
    FUNC_RLT    = 3'd2,
    FUNC_SEARCH = 3'd3,
    FUNC_SORTED = 3'd4
  } func_e;

  typedef struct packed {
    logic                     ok;
    logic signed [DataW-1:0]  head_value;
    logic [FoundW-1:0]        found_index;
    logic [CountW-1:0]        removed_count;
    logic [CountW-1:0]        occupancy;
  } result_t;

endpackage

// File: rtl/core/bsl_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsl_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bsl_mem #(
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AddrW-1:0]            waddr_i,
  input  logic [bsl_pkg::DataW-1:0]   wdata_i,
  input  logic                        re_i,
  input  logic [AddrW-1:0]            raddr_i,
  output logic [bsl_pkg::DataW-1:0]   rdata_o
);

  logic [bsl_pkg::DataW-1:0] mem [Depth];
  logic [bsl_pkg::DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/bsl_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsl_seq
// Operation sequencer: walks the entry store one entry per read/evaluate
// pair, shifting or compacting entries as it goes.
// ----------------------------------------------------------------------------
`include "bounded_sorted_list_engine_assert.svh"

module bsl_seq #(
  parameter int unsigned Capacity = 16,
  localparam int unsigned CntW  = $clog2(Capacity + 1),
  localparam int unsigned AddrW = $clog2(Capacity)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [bsl_pkg::FuncW-1:0]          func_i,
  input  logic signed [bsl_pkg::DataW-1:0]   operand_value_i,
  output logic                               res_valid_o,
  input  logic                               res_ready_i,
  output bsl_pkg::result_t                   res_o,
  output logic                               mem_we_o,
  output logic [AddrW-1:0]                   mem_waddr_o,
  output logic [bsl_pkg::DataW-1:0]          mem_wdata_o,
  output logic                               mem_re_o,
  output logic [AddrW-1:0]                   mem_raddr_o,
  input  logic [bsl_pkg::DataW-1:0]          mem_rdata_i
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_EVAL = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  localparam logic [CntW-1:0] CapCnt = CntW'(Capacity);
  localparam logic [CntW-1:0] One    = CntW'(1);

  state_e                          state_q, state_d;
  bsl_pkg::func_e                  func_q, func_d;
  logic signed [bsl_pkg::DataW-1:0] val_q, val_d;
  logic signed [bsl_pkg::DataW-1:0] prev_q, prev_d;
  logic signed [bsl_pkg::DataW-1:0] head_q, head_d;
  logic [CntW-1:0]                 cnt_q, cnt_d;
  logic [CntW-1:0]                 idx_q, idx_d;
  logic [CntW-1:0]                 wr_q, wr_d;
  logic [CntW-1:0]                 found_q, found_d;
  logic [CntW-1:0]                 removed_q, removed_d;
  logic                            ok_q, ok_d;

  logic [CntW-1:0]                 idx_m1;
  logic signed [bsl_pkg::DataW-1:0] rd_val;
  logic [CntW+bsl_pkg::FoundW-1:0] found_ext;
  logic [CntW+bsl_pkg::CountW-1:0] removed_ext;
  logic [CntW+bsl_pkg::CountW-1:0] cnt_ext;

  assign idx_m1 = idx_q - One;
  assign rd_val = $signed(mem_rdata_i);

  always_comb begin
    state_d   = state_q;
    func_d    = func_q;
    val_d     = val_q;
    prev_d    = prev_q;
    head_d    = head_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    wr_d      = wr_q;
    found_d   = found_q;
    removed_d = removed_q;
    ok_d      = ok_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = '0;
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          func_d    = bsl_pkg::func_e'(func_i);
          val_d     = operand_value_i;
          ok_d      = 1'b0;
          head_d    = '0;
          found_d   = '0;
          removed_d = '0;
          idx_d     = '0;
          wr_d      = '0;
          state_d   = S_READ;
          unique case (bsl_pkg::func_e'(func_i))
            bsl_pkg::FUNC_INSERT: begin
              // walk down from the top, shifting entries up by one
              if (cnt_q == CapCnt) state_d = S_DONE;
              else                 idx_d   = cnt_q;
            end
            bsl_pkg::FUNC_POP: begin
              if (cnt_q == '0) state_d = S_DONE;
            end
            bsl_pkg::FUNC_RLT, bsl_pkg::FUNC_SEARCH, bsl_pkg::FUNC_SORTED: begin
              state_d = S_READ;
            end
            default: state_d = S_DONE;
          endcase
        end
      end

      S_READ: begin
        if (func_q == bsl_pkg::FUNC_INSERT) begin
          if (idx_q == '0) begin
            mem_we_o    = 1'b1;
            mem_waddr_o = '0;
            mem_wdata_o = val_q;
            cnt_d       = cnt_q + One;
            ok_d        = 1'b1;
            state_d     = S_DONE;
          end else begin
            mem_re_o    = 1'b1;
            mem_raddr_o = idx_m1[AddrW-1:0];
            state_d     = S_EVAL;
          end
        end else if (idx_q == cnt_q) begin
          // end of the walk
          state_d = S_DONE;
          unique case (func_q)
            bsl_pkg::FUNC_POP: begin
              cnt_d = cnt_q - One;
              ok_d  = 1'b1;
            end
            bsl_pkg::FUNC_RLT: begin
              removed_d = cnt_q - wr_q;
              cnt_d     = wr_q;
              ok_d      = 1'b1;
            end
            bsl_pkg::FUNC_SORTED: ok_d = 1'b1;
            default:              ok_d = 1'b0;
          endcase
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = idx_q[AddrW-1:0];
          state_d     = S_EVAL;
        end
      end

      S_EVAL: begin
        state_d = S_READ;
        idx_d   = idx_q + One;
        unique case (func_q)
          bsl_pkg::FUNC_INSERT: begin
            mem_we_o    = 1'b1;
            mem_waddr_o = idx_q[AddrW-1:0];
            if (rd_val < val_q) begin
              mem_wdata_o = val_q;
              cnt_d       = cnt_q + One;
              ok_d        = 1'b1;
              state_d     = S_DONE;
            end else begin
              mem_wdata_o = rd_val;
              idx_d       = idx_m1;
            end
          end
          bsl_pkg::FUNC_POP: begin
            if (idx_q == '0) begin
              head_d = rd_val;
            end else begin
              mem_we_o    = 1'b1;
              mem_waddr_o = idx_m1[AddrW-1:0];
              mem_wdata_o = rd_val;
            end
          end
          bsl_pkg::FUNC_RLT: begin
            if (!(rd_val < val_q)) begin
              mem_we_o    = 1'b1;
              mem_waddr_o = wr_q[AddrW-1:0];
              mem_wdata_o = rd_val;
              wr_d        = wr_q + One;
            end
          end
          bsl_pkg::FUNC_SEARCH: begin
            if (rd_val == val_q) begin
              ok_d    = 1'b1;
              found_d = idx_q;
              state_d = S_DONE;
            end
          end
          bsl_pkg::FUNC_SORTED: begin
            if ((idx_q != '0) && (rd_val < prev_q)) begin
              ok_d    = 1'b0;
              state_d = S_DONE;
            end else begin
              prev_d = rd_val;
            end
          end
          default: state_d = S_DONE;
        endcase
      end

      S_DONE: begin
        if (res_ready_i) state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q    <= func_d;
    val_q     <= val_d;
    prev_q    <= prev_d;
    head_q    <= head_d;
    idx_q     <= idx_d;
    wr_q      <= wr_d;
    found_q   <= found_d;
    removed_q <= removed_d;
    ok_q      <= ok_d;
  end

  // result fields carry only their low bits
  assign found_ext   = {{bsl_pkg::FoundW{1'b0}}, found_q};
  assign removed_ext = {{bsl_pkg::CountW{1'b0}}, removed_q};
  assign cnt_ext     = {{bsl_pkg::CountW{1'b0}}, cnt_q};

  assign in_stall_o  = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_DONE);

  always_comb begin
    res_o.ok            = ok_q;
    res_o.head_value    = head_q;
    res_o.found_index   = found_ext[bsl_pkg::FoundW-1:0];
    res_o.removed_count = removed_ext[bsl_pkg::CountW-1:0];
    res_o.occupancy     = cnt_ext[bsl_pkg::CountW-1:0];
  end

  `BSL_ASSERT_NR(a_cnt_bound, (!rst_ni || (cnt_q <= CapCnt)), "entry count above capacity")
  `BSL_ASSERT(a_read_then_eval, (mem_re_o |=> (state_q == S_EVAL)), "read not evaluated")
  `BSL_ASSERT(a_write_in_list, (mem_we_o |-> (CntW'(mem_waddr_o) <= cnt_q)), "write past list end")
  `BSL_ASSERT(a_res_hold, ((res_valid_o && !res_ready_i) |=> (res_valid_o && $stable(res_o))), "result moved while held")

endmodule

// File: rtl/core/bounded_sorted_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_sorted_list_engine
// Fixed-capacity sorted list of signed 32-bit values held in a one-read,
// one-write entry store, with insert, pop, remove-below, search and order check.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+----------------------------------
//   in      | input     | in_valid_i/stall_o  | func_i, operand_value_i
//   out     | output    | out_valid_o/stall_i | ok_o, head_value_o, found_index_o,
//           |           |                     | removed_count_o, occupancy_o
//
// The sequencer reads and then evaluates each entry visited, in its S_READ
// and S_EVAL states, as the store returns registered read data. The longest
// operations are pop, remove-below, a missed search or an order check over
// a full list.
// After reset the list is empty; the store itself is not cleared.
// in_stall_o is high from acceptance until the result is handed to the output
// register; a finished result waits there without holding off the next input.
// ----------------------------------------------------------------------------
module bounded_sorted_list_engine #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [bsl_pkg::FuncW-1:0]         func_i,
  input  logic signed [bsl_pkg::DataW-1:0]  operand_value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              ok_o,
  output logic signed [bsl_pkg::DataW-1:0]  head_value_o,
  output logic [bsl_pkg::FoundW-1:0]        found_index_o,
  output logic [bsl_pkg::CountW-1:0]        removed_count_o,
  output logic [bsl_pkg::CountW-1:0]        occupancy_o
);

  localparam int unsigned AddrW = $clog2(CAPACITY);

  logic                        mem_we;
  logic [AddrW-1:0]            mem_waddr;
  logic [bsl_pkg::DataW-1:0]   mem_wdata;
  logic                        mem_re;
  logic [AddrW-1:0]            mem_raddr;
  logic [bsl_pkg::DataW-1:0]   mem_rdata;

  logic                        res_valid;
  logic                        res_ready;
  bsl_pkg::result_t            res;

  logic                        out_valid_q, out_valid_d;
  bsl_pkg::result_t            out_q;

  bsl_mem #(
    .Depth (CAPACITY)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  bsl_seq #(
    .Capacity (CAPACITY)
  ) u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .func_i          (func_i),
    .operand_value_i (operand_value_i),
    .res_valid_o     (res_valid),
    .res_ready_i     (res_ready),
    .res_o           (res),
    .mem_we_o        (mem_we),
    .mem_waddr_o     (mem_waddr),
    .mem_wdata_o     (mem_wdata),
    .mem_re_o        (mem_re),
    .mem_raddr_o     (mem_raddr),
    .mem_rdata_i     (mem_rdata)
  );

  // output register takes a result when empty or being drained
  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign ok_o            = out_q.ok;
  assign head_value_o    = out_q.head_value;
  assign found_index_o   = out_q.found_index;
  assign removed_count_o = out_q.removed_count;
  assign occupancy_o     = out_q.occupancy;

endmodule
